>>> rtl/dtv_pkg.sv
// Shared types and constants for the decimal token validator.
// No dependencies; every other rtl file refers to it by scoped names.
`default_nettype none

package dtv_pkg;

	localparam int CharW  = 8;
	localparam int MagW   = 21;
	localparam int LimW   = 20;
	localparam int FracW  = 2;
	localparam int CountW = 16;
	localparam int SumW   = 37;
	localparam int CandW  = 25;
	localparam int AddrW  = 3;
	localparam int DataW  = 32;

	localparam logic [CountW-1:0] CountMax   = 16'hFFFF;
	localparam logic [FracW-1:0]  FracCap    = 2'd2;
	localparam logic [FracW-1:0]  FracReset  = 2'd2;
	localparam logic [LimW-1:0]   LimitReset = 20'd100000;

	localparam logic [CharW-1:0] ChMinus = 8'h2D;
	localparam logic [CharW-1:0] ChPoint = 8'h2E;
	localparam logic [CharW-1:0] ChZero  = 8'h30;
	localparam logic [CharW-1:0] ChNine  = 8'h39;

	localparam logic RegFrac  = 1'b0;
	localparam logic RegLimit = 1'b1;

	typedef enum logic [6:0] {
		PH_START = 7'b0000001,
		PH_SIGN  = 7'b0000010,
		PH_ZERO  = 7'b0000100,
		PH_INT   = 7'b0001000,
		PH_POINT = 7'b0010000,
		PH_FRAC  = 7'b0100000,
		PH_ERROR = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [FracW-1:0] max_frac;
		logic [LimW-1:0]  limit;
	} cfg_t;

	typedef struct packed {
		logic                   done;
		logic                   legal;
		logic signed [MagW-1:0] value;
	} token_t;

endpackage

`default_nettype wire

>>> rtl/dtv_cfg.sv
// APB-style configuration registers of the decimal token validator.
// Depends on dtv_pkg.
`default_nettype none

module dtv_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [dtv_pkg::AddrW-1:0]   paddr,
	input  wire logic [dtv_pkg::DataW-1:0]   pwdata,
	output      logic [dtv_pkg::DataW-1:0]   prdata,
	output      logic                        pready,
	output      dtv_pkg::cfg_t               cfg
);

	logic [dtv_pkg::FracW-1:0] frac_q;
	logic [dtv_pkg::LimW-1:0]  limit_q;
	logic                      wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q  <= dtv_pkg::FracReset;
			limit_q <= dtv_pkg::LimitReset;
		end else if (wr) begin
			unique case (paddr[2])
				dtv_pkg::RegFrac:  frac_q  <= pwdata[dtv_pkg::FracW-1:0];
				dtv_pkg::RegLimit: limit_q <= pwdata[dtv_pkg::LimW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			dtv_pkg::RegFrac:  prdata = {{(dtv_pkg::DataW-dtv_pkg::FracW){1'b0}}, frac_q};
			dtv_pkg::RegLimit: prdata = {{(dtv_pkg::DataW-dtv_pkg::LimW){1'b0}}, limit_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.max_frac = frac_q;
	assign cfg.limit    = limit_q;

endmodule

`default_nettype wire

>>> rtl/dtv_parse.sv
// Token parser: phase, sign, fraction count and saturating magnitude.
// Depends on dtv_pkg; consumes one registered character per take.
`default_nettype none

module dtv_parse (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire dtv_pkg::cfg_t               cfg,
	input  wire logic                        take,
	input  wire logic [dtv_pkg::CharW-1:0]   character,
	input  wire logic                        token_end,
	output      dtv_pkg::token_t             token
);

	dtv_pkg::phase_t               phase_q, phase_n;
	logic                          neg_q, neg_n;
	logic [dtv_pkg::FracW-1:0]     frac_q, frac_n;
	logic [dtv_pkg::MagW-1:0]      mag_q, mag_n;
	logic                          over_q, over_n;

	logic                          digit;
	logic [3:0]                    d;
	logic [dtv_pkg::FracW-1:0]     maxf;
	logic [dtv_pkg::CandW-1:0]     d100, d10, mag_x10, frac_add, cand;
	logic                          grow;
	logic                          ends_ok;

	assign digit = (character >= dtv_pkg::ChZero) && (character <= dtv_pkg::ChNine);
	assign d     = digit ? character[3:0] : 4'd0;
	assign maxf  = (cfg.max_frac > dtv_pkg::FracCap) ? dtv_pkg::FracCap : cfg.max_frac;

	assign d100     = {15'd0, d, 6'd0} + {16'd0, d, 5'd0} + {19'd0, d, 2'd0};
	assign d10      = {18'd0, d, 3'd0} + {20'd0, d, 1'd0};
	assign mag_x10  = {1'b0, mag_q, 3'd0} + {3'd0, mag_q, 1'd0};
	assign frac_add = (frac_q == '0) ? d10 : {21'd0, d};

	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		frac_n  = frac_q;
		grow    = 1'b0;
		cand    = '0;
		unique case (phase_q)
			dtv_pkg::PH_START, dtv_pkg::PH_SIGN: begin
				if (phase_q == dtv_pkg::PH_START && character == dtv_pkg::ChMinus) begin
					neg_n   = 1'b1;
					phase_n = dtv_pkg::PH_SIGN;
				end else if (digit && d == 4'd0) begin
					phase_n = dtv_pkg::PH_ZERO;
				end else if (digit) begin
					grow    = 1'b1;
					cand    = d100;
					phase_n = dtv_pkg::PH_INT;
				end else begin
					phase_n = dtv_pkg::PH_ERROR;
				end
			end
			dtv_pkg::PH_ZERO, dtv_pkg::PH_INT: begin
				if (character == dtv_pkg::ChPoint) begin
					phase_n = dtv_pkg::PH_POINT;
				end else if (digit && phase_q == dtv_pkg::PH_INT) begin
					grow = 1'b1;
					cand = mag_x10 + d100;
				end else begin
					phase_n = dtv_pkg::PH_ERROR;
				end
			end
			dtv_pkg::PH_POINT, dtv_pkg::PH_FRAC: begin
				if (digit && frac_q < maxf) begin
					grow    = 1'b1;
					cand    = {4'd0, mag_q} + frac_add;
					frac_n  = frac_q + 2'd1;
					phase_n = dtv_pkg::PH_FRAC;
				end else begin
					phase_n = dtv_pkg::PH_ERROR;
				end
			end
			default: phase_n = dtv_pkg::PH_ERROR;
		endcase
	end

	always_comb begin
		mag_n  = mag_q;
		over_n = over_q;
		if (grow && !over_q) begin
			if (cand > {5'd0, cfg.limit}) begin
				over_n = 1'b1;
				mag_n  = {1'b0, cfg.limit} + 21'd1;
			end else begin
				mag_n = cand[dtv_pkg::MagW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dtv_pkg::PH_START;
			neg_q   <= 1'b0;
			frac_q  <= '0;
			mag_q   <= '0;
			over_q  <= 1'b0;
		end else if (take) begin
			if (token_end) begin
				phase_q <= dtv_pkg::PH_START;
				neg_q   <= 1'b0;
				frac_q  <= '0;
				mag_q   <= '0;
				over_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				frac_q  <= frac_n;
				mag_q   <= mag_n;
				over_q  <= over_n;
			end
		end
	end

	assign ends_ok = (phase_n == dtv_pkg::PH_ZERO) || (phase_n == dtv_pkg::PH_INT) ||
		(phase_n == dtv_pkg::PH_POINT) || (phase_n == dtv_pkg::PH_FRAC);

	assign token.done  = take && token_end;
	assign token.legal = ends_ok && !over_n;
	assign token.value = !token.legal ? '0 :
		(neg_n ? -$signed(mag_n) : $signed(mag_n));

endmodule

`default_nettype wire

>>> rtl/dtv_accum.sv
// Legal-token count and sum, plus the result register.
// Depends on dtv_pkg; loads on each finished token from dtv_parse.
`default_nettype none

module dtv_accum (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire dtv_pkg::token_t                    token,
	input  wire logic                               result_ready,
	output      logic                               result_valid,
	output      logic                               legal,
	output      logic signed [dtv_pkg::MagW-1:0]    value_hundredths,
	output      logic [dtv_pkg::CountW-1:0]         legal_total,
	output      logic signed [dtv_pkg::SumW-1:0]    legal_sum
);

	logic                            valid_s2;
	logic                            legal_s2;
	logic signed [dtv_pkg::MagW-1:0] value_s2;
	logic [dtv_pkg::CountW-1:0]      count_q;
	logic signed [dtv_pkg::SumW-1:0] sum_q;
	logic                            bump;

	assign bump = token.done && token.legal && (count_q != dtv_pkg::CountMax);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			count_q  <= '0;
			sum_q    <= '0;
		end else begin
			if (token.done) begin
				valid_s2 <= 1'b1;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
			if (bump) begin
				count_q <= count_q + 16'd1;
				sum_q   <= sum_q + {{(dtv_pkg::SumW-dtv_pkg::MagW){token.value[dtv_pkg::MagW-1]}},
					token.value};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (token.done) begin
			legal_s2 <= token.legal;
			value_s2 <= token.value;
		end
	end

	assign result_valid     = valid_s2;
	assign legal            = legal_s2;
	assign value_hundredths = value_s2;
	assign legal_total      = count_q;
	assign legal_sum        = sum_q;

endmodule

`default_nettype wire

>>> rtl/decimal_token_validator.sv
// Path: last character -> input register -> parser -> result register.
// Throughput: one character per cycle; the input register and the parser advance
// together, except that a token's last character waits while a result is unread.
// Reset: arst_n clears the parser, the count, the sum and both valid flags at once;
// the registers return to 2 fraction digits and a limit of 100000.
// Top level; depends on dtv_pkg, dtv_cfg, dtv_parse and dtv_accum.
`default_nettype none

module decimal_token_validator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [dtv_pkg::AddrW-1:0]          paddr,
	input  wire logic [dtv_pkg::DataW-1:0]          pwdata,
	output      logic [dtv_pkg::DataW-1:0]          prdata,
	output      logic                               pready,
	input  wire logic                               item_valid,
	output      logic                               item_ready,
	input  wire logic [dtv_pkg::CharW-1:0]          character,
	input  wire logic                               token_end,
	output      logic                               result_valid,
	input  wire logic                               result_ready,
	output      logic                               legal,
	output      logic signed [dtv_pkg::MagW-1:0]    value_hundredths,
	output      logic [dtv_pkg::CountW-1:0]         legal_total,
	output      logic signed [dtv_pkg::SumW-1:0]    legal_sum
);

	dtv_pkg::cfg_t             cfg;
	dtv_pkg::token_t           tok;
	logic                      valid_s1;
	logic [dtv_pkg::CharW-1:0] character_s1;
	logic                      token_end_s1;
	logic                      take;

	dtv_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// hold the last character while the previous result waits
	assign take       = valid_s1 && !(token_end_s1 && result_valid && !result_ready);
	assign item_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			character_s1 <= character;
			token_end_s1 <= token_end;
		end
	end

	dtv_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.take      (take),
		.character (character_s1),
		.token_end (token_end_s1),
		.token     (tok)
	);

	dtv_accum u_accum (
		.clk              (clk),
		.arst_n           (arst_n),
		.token            (tok),
		.result_ready     (result_ready),
		.result_valid     (result_valid),
		.legal            (legal),
		.value_hundredths (value_hundredths),
		.legal_total      (legal_total),
		.legal_sum        (legal_sum)
	);

	a_illegal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !legal |-> value_hundredths == '0)
		else $error("illegal token carries a nonzero value");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item_ready)
		else $error("input stage empty but not ready");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!tok.done |=> $stable(legal_total))
		else $error("legal count moved without a finished token");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !tok.done)
		else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

>>> tb/tb_decimal_token_validator.sv
// Testbench for decimal_token_validator: random and directed character streams,
// a scoreboard that predicts each token's result and checks it field by field.
// Depends on dtv_pkg and the decimal_token_validator RTL.
`timescale 1ns / 1ps

module tb_decimal_token_validator;

	localparam int unsigned QuietLimit = 3000;
	localparam int unsigned HoldCycles = 400;
	localparam int unsigned PhaseChars = 125;

	typedef struct {
		bit                                      legal;
		logic signed [dtv_pkg::MagW-1:0]         value;
		logic [dtv_pkg::CountW-1:0]              total;
		logic signed [dtv_pkg::SumW-1:0]         sum;
	} token_result_t;

	class token_scoreboard;
		logic [dtv_pkg::FracW-1:0] frac_max;
		logic [dtv_pkg::LimW-1:0]  limit;
		dtv_pkg::phase_t           phase;
		bit                        negative;
		int unsigned               frac_seen;
		longint unsigned           magnitude;
		bit                        over;
		int unsigned               legal_count;
		longint                    legal_total_sum;
		token_result_t             pending[$];
		int unsigned               faults;

		function new();
			frac_max = dtv_pkg::FracReset;
			limit = dtv_pkg::LimitReset;
			legal_count = 0;
			legal_total_sum = 0;
			faults = 0;
			clear_token();
		endfunction

		function void clear_token();
			phase = dtv_pkg::PH_START;
			negative = 1'b0;
			frac_seen = 0;
			magnitude = 0;
			over = 1'b0;
		endfunction

		function void grow(longint unsigned nxt);
			if (over)
				return;
			if (nxt > limit) begin
				over = 1'b1;
				magnitude = limit + 1;
			end else begin
				magnitude = nxt;
			end
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			faults++;
		endtask

		function void take_char(logic [dtv_pkg::CharW-1:0] ch, bit last);
			bit is_digit;
			int unsigned d;
			int unsigned cap;
			bit ok;
			longint v;
			token_result_t r;
			is_digit = ch >= dtv_pkg::ChZero && ch <= dtv_pkg::ChNine;
			d = is_digit ? int'(ch - dtv_pkg::ChZero) : 0;
			cap = (frac_max > dtv_pkg::FracCap) ? dtv_pkg::FracCap : frac_max;
			case (phase)
				dtv_pkg::PH_START, dtv_pkg::PH_SIGN: begin
					if (phase == dtv_pkg::PH_START && ch == dtv_pkg::ChMinus) begin
						negative = 1'b1;
						phase = dtv_pkg::PH_SIGN;
					end else if (is_digit && d == 0) begin
						phase = dtv_pkg::PH_ZERO;
					end else if (is_digit) begin
						grow(d * 100);
						phase = dtv_pkg::PH_INT;
					end else begin
						phase = dtv_pkg::PH_ERROR;
					end
				end
				dtv_pkg::PH_ZERO, dtv_pkg::PH_INT: begin
					if (ch == dtv_pkg::ChPoint) begin
						phase = dtv_pkg::PH_POINT;
					end else if (is_digit && phase == dtv_pkg::PH_INT) begin
						grow(magnitude * 10 + d * 100);
					end else begin
						phase = dtv_pkg::PH_ERROR;
					end
				end
				dtv_pkg::PH_POINT, dtv_pkg::PH_FRAC: begin
					if (is_digit && frac_seen < cap) begin
						grow(magnitude + d * ((frac_seen == 0) ? 10 : 1));
						frac_seen++;
						phase = dtv_pkg::PH_FRAC;
					end else begin
						phase = dtv_pkg::PH_ERROR;
					end
				end
				default: begin
					phase = dtv_pkg::PH_ERROR;
				end
			endcase
			if (!last)
				return;
			ok = !over && (phase inside {dtv_pkg::PH_ZERO, dtv_pkg::PH_INT,
				dtv_pkg::PH_POINT, dtv_pkg::PH_FRAC});
			v = 0;
			if (ok) begin
				v = negative ? -longint'(magnitude) : longint'(magnitude);
				if (legal_count < dtv_pkg::CountMax) begin
					legal_count++;
					legal_total_sum += v;
				end
			end
			r.legal = ok;
			r.value = v[dtv_pkg::MagW-1:0];
			r.total = legal_count[dtv_pkg::CountW-1:0];
			r.sum = legal_total_sum[dtv_pkg::SumW-1:0];
			pending.push_back(r);
			clear_token();
		endfunction

		task compare_result(bit lg, logic signed [dtv_pkg::MagW-1:0] val,
				logic [dtv_pkg::CountW-1:0] tot, logic signed [dtv_pkg::SumW-1:0] sm);
			token_result_t r;
			if (pending.size() == 0) begin
				report("result with nothing expected");
			end else begin
				r = pending.pop_front();
				if (lg !== r.legal)
					report($sformatf("legal %0b, expected %0b", lg, r.legal));
				if (val !== r.value)
					report($sformatf("value_hundredths %0d, expected %0d", val, r.value));
				if (tot !== r.total)
					report($sformatf("legal_total %0d, expected %0d", tot, r.total));
				if (sm !== r.sum)
					report($sformatf("legal_sum %0d, expected %0d", sm, r.sum));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [dtv_pkg::AddrW-1:0] paddr;
	logic [dtv_pkg::DataW-1:0] pwdata;
	logic [dtv_pkg::DataW-1:0] prdata;
	logic pready;
	logic item_valid, item_ready;
	logic [dtv_pkg::CharW-1:0] character;
	logic token_end;
	logic result_valid, result_ready;
	logic legal;
	logic signed [dtv_pkg::MagW-1:0] value_hundredths;
	logic [dtv_pkg::CountW-1:0] legal_total;
	logic signed [dtv_pkg::SumW-1:0] legal_sum;

	token_scoreboard sb;
	int unsigned send_idle_pct;
	int unsigned stall_pct;
	int unsigned hold_asked;
	int unsigned hold_given;
	int unsigned hold_left;
	int unsigned quiet_cycles;
	int unsigned chars_sent;
	logic [dtv_pkg::CharW-1:0] token_buf[$];

	decimal_token_validator dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.character(character),
		.token_end(token_end),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.legal(legal),
		.value_hundredths(value_hundredths),
		.legal_total(legal_total),
		.legal_sum(legal_sum)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// drain results, stall at random, hold off once per request
	always @(posedge clk) begin
		if (result_valid && result_ready)
			sb.compare_result(legal, value_hundredths, legal_total, legal_sum);
		if (hold_left != 0) begin
			result_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_asked != hold_given) begin
			hold_given <= hold_given + 1;
			hold_left <= HoldCycles;
			result_ready <= 1'b0;
		end else begin
			result_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [dtv_pkg::CharW-1:0] digit_char(int unsigned d);
		return dtv_pkg::CharW'(dtv_pkg::ChZero + d);
	endfunction

	function automatic logic [dtv_pkg::CharW-1:0] mutant_char();
		case ($urandom_range(3))
			0: return dtv_pkg::ChMinus;
			1: return dtv_pkg::ChPoint;
			2: return dtv_pkg::ChZero;
			default: return dtv_pkg::CharW'($urandom_range(255));
		endcase
	endfunction

	// mostly well-formed numbers, some broken ones, some raw bytes
	function automatic void make_token();
		int unsigned kind;
		int unsigned n;
		int unsigned pos;
		kind = $urandom_range(99);
		token_buf.delete();
		if (kind < 10) begin
			n = $urandom_range(1, 4);
			repeat (n) token_buf.push_back(dtv_pkg::CharW'($urandom_range(255)));
			return;
		end
		if ($urandom_range(2) == 0)
			token_buf.push_back(dtv_pkg::ChMinus);
		if ($urandom_range(4) == 0) begin
			token_buf.push_back(dtv_pkg::ChZero);
		end else begin
			n = ($urandom_range(3) == 0) ? $urandom_range(4, 7) : $urandom_range(1, 3);
			token_buf.push_back(digit_char($urandom_range(1, 9)));
			repeat (n - 1) token_buf.push_back(digit_char($urandom_range(9)));
		end
		if ($urandom_range(1) == 1) begin
			token_buf.push_back(dtv_pkg::ChPoint);
			n = ($urandom_range(5) == 0) ? 3 : $urandom_range(2);
			repeat (n) token_buf.push_back(digit_char($urandom_range(9)));
		end
		if (kind < 30) begin
			pos = $urandom_range(token_buf.size() - 1);
			if ($urandom_range(1) == 0)
				token_buf[pos] = mutant_char();
			else
				token_buf.insert(pos, mutant_char());
		end
	endfunction

	task automatic send_char(logic [dtv_pkg::CharW-1:0] ch, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		character <= ch;
		token_end <= last;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.take_char(ch, last);
		chars_sent++;
	endtask

	task automatic send_text(string s, bit last);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], last && i == s.len() - 1);
	endtask

	task automatic send_buffer();
		for (int i = 0; i < token_buf.size(); i++)
			send_char(token_buf[i], i == token_buf.size() - 1);
	endtask

	// hold until every result is back, then let the pipeline settle
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_register(logic reg_sel, logic [dtv_pkg::DataW-1:0] value,
			logic [dtv_pkg::DataW-1:0] mask);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= ($urandom() & ~mask) | (value & mask);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (reg_sel == dtv_pkg::RegFrac)
			sb.frac_max = value[dtv_pkg::FracW-1:0];
		else
			sb.limit = value[dtv_pkg::LimW-1:0];
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if ((prdata & mask) !== (value & mask))
			sb.report($sformatf("register %0d reads %0h, expected %0h", reg_sel,
				prdata & mask, value & mask));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(int unsigned frac, int unsigned lim);
		set_register(dtv_pkg::RegFrac, frac, (1 << dtv_pkg::FracW) - 1);
		set_register(dtv_pkg::RegLimit, lim, (1 << dtv_pkg::LimW) - 1);
	endtask

	initial begin
		int unsigned lim;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		character = '0;
		token_end = 1'b0;
		result_ready = 1'b0;
		send_idle_pct = 0;
		stall_pct = 0;
		hold_asked = 0;
		hold_given = 0;
		hold_left = 0;
		quiet_cycles = 0;
		chars_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("-", 1);
		send_text("-0.0", 1);
		send_text("12.", 1);
		send_text("0.123", 1);
		send_text("1000", 1);
		send_text("1001", 1);
		send_text("00", 1);
		send_text("1..", 1);
		send_text("5-", 1);
		send_char(8'h00, 1);
		send_char(8'hFF, 1);

		for (int p = 0; p < 8; p++) begin
			drain();
			case (p)
				0: configure(0, 0);
				1: configure(3, (1 << dtv_pkg::LimW) - 1);
				2: configure(1, 1000000);
				3: configure(2, 500);
				4: configure(2, 100000);
				5: begin
					lim = $urandom_range((1 << dtv_pkg::LimW) - 1);
					configure(0, lim);
				end
				6: begin
					lim = $urandom_range(1000, 200000);
					configure(1, lim);
				end
				default: configure(3, 99999);
			endcase
			send_idle_pct = (p % 4 == 1) ? 62 : (p % 4 == 3) ? 9 : 0;
			stall_pct = (p % 4 == 2) ? 62 : (p % 4 == 3) ? 9 : 0;
			if (p == 4)
				hold_asked++;
			chars_sent = 0;
			while (chars_sent < PhaseChars) begin
				make_token();
				send_buffer();
			end
			// leave a token open across the register write
			if (p % 2 == 1) begin
				send_char(dtv_pkg::ChMinus, 0);
				send_char(digit_char(4), 0);
			end
		end

		drain();
		configure(2, 100000);
		send_idle_pct = 0;
		stall_pct = 0;
		repeat (20) begin
			make_token();
			send_buffer();
		end

		item_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.faults == 0 && sb.pending.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/dtv_pkg.sv
rtl/dtv_cfg.sv
rtl/dtv_parse.sv
rtl/dtv_accum.sv
rtl/decimal_token_validator.sv
tb/tb_decimal_token_validator.sv
